// ===== rtl/lru_replacer_unit_assert.svh =====
// Assertion macros used by the replacer top level.
`ifndef LRU_REPLACER_UNIT_ASSERT_SVH
`define LRU_REPLACER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lru_pkg.sv =====
// Package: request and status codes of the LRU replacer.
`timescale 1ns / 1ps
package lru_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_VICTIM = 2'd1,
        OP_ERASE  = 2'd2,
        OP_BAD    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 2;

endpackage

// ===== rtl/lru_front.sv =====
// Front end: accepts request beats, decodes the kind, queues them for the back end.
`timescale 1ns / 1ps
module lru_front #(
    parameter int unsigned KEY_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [lru_pkg::KIND_W-1:0] i_kind,
    input  logic [KEY_WIDTH-1:0]     i_key,
    output logic                     o_q_valid,
    input  logic                     i_q_pop,
    output lru_pkg::t_op             o_q_op,
    output logic [KEY_WIDTH-1:0]     o_q_key
);
    import lru_pkg::*;

    localparam int unsigned QD = 2;

    t_op                  r_q_op  [QD];
    logic [KEY_WIDTH-1:0] r_q_key [QD];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_fill;
    t_op                  w_op;
    logic                 w_push;
    logic                 w_pop;

    always_comb begin
        case (i_kind)
            KIND_W'(OP_INSERT): w_op = OP_INSERT;
            KIND_W'(OP_VICTIM): w_op = OP_VICTIM;
            KIND_W'(OP_ERASE):  w_op = OP_ERASE;
            default:            w_op = OP_BAD;
        endcase
    end

    assign o_ready   = (r_fill != 2'(QD));
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_fill != 2'd0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_op    = r_q_op[r_rd_ptr];
    assign o_q_key   = r_q_key[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_op[r_wr_ptr]  <= w_op;
            r_q_key[r_wr_ptr] <= i_key;
        end
    end

endmodule

// ===== rtl/lru_back.sv =====
// Back end: compare-and-shift recency list, executes one request at a time.
`timescale 1ns / 1ps
module lru_back #(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned KEY_WIDTH = 16,
    parameter int unsigned CW        = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  lru_pkg::t_op         i_q_op,
    input  logic [KEY_WIDTH-1:0] i_q_key,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lru_pkg::t_status     o_status,
    output logic [KEY_WIDTH-1:0] o_victim,
    output logic [CW-1:0]        o_count
);
    import lru_pkg::*;

    localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic {S_CMP, S_EXEC} t_state;

    t_state               r_state;
    logic [KEY_WIDTH-1:0] r_list [CAPACITY];
    logic [CW-1:0]        r_count;
    logic                 r_hit;
    logic [PW-1:0]        r_pos;
    logic                 r_out_valid;
    t_status              r_status;
    logic [KEY_WIDTH-1:0] r_victim;

    t_status              n_status;
    logic [KEY_WIDTH-1:0] n_victim;
    logic [CW-1:0]        n_count;

    logic                 w_hit;
    logic [PW-1:0]        w_pos;
    logic                 w_exec;
    logic                 w_full;
    logic                 w_empty;
    logic [CW-1:0]        w_cnt_m1;
    logic                 w_do_ins;
    logic                 w_do_era;

    // parallel match over the valid part of the list; keys are distinct
    always_comb begin
        w_hit = 1'b0;
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if ((CW'(i) < r_count) && (r_list[i] == i_q_key)) begin
                w_hit = 1'b1;
                w_pos = w_pos | PW'(i);
            end
        end
    end

    assign w_exec   = (r_state == S_EXEC) && (!r_out_valid || i_ready);
    assign o_q_pop  = w_exec;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_do_ins = w_exec && (i_q_op == OP_INSERT) && (r_hit || !w_full);
    assign w_do_era = w_exec && (i_q_op == OP_ERASE) && r_hit;

    always_comb begin
        n_status = ST_OK;
        n_victim = '0;
        n_count  = r_count;
        case (i_q_op)
            OP_INSERT: begin
                if (!r_hit) begin
                    if (w_full) n_status = ST_FULL;
                    else        n_count  = r_count + CW'(1);
                end
            end
            OP_VICTIM: begin
                if (w_empty) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_victim = r_list[w_cnt_m1[PW-1:0]];
                    n_count  = w_cnt_m1;
                end
            end
            OP_ERASE: begin
                if (r_hit) n_count  = w_cnt_m1;
                else       n_status = ST_NOTFOUND;
            end
            default: n_status = ST_NOTFOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CMP;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_victim    <= '0;
        end else begin
            if (w_exec)       r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_CMP: begin
                    if (i_q_valid) begin
                        r_hit   <= w_hit;
                        r_pos   <= w_pos;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_exec) begin
                        r_status <= n_status;
                        r_victim <= n_victim;
                        r_count  <= n_count;
                        r_state  <= S_CMP;
                    end
                end
                default: r_state <= S_CMP;
            endcase
        end
    end

    // list shifts: toward the tail on insert, toward the head on erase
    always_ff @(posedge i_clk) begin
        if (w_do_ins) begin
            r_list[0] <= i_q_key;
            for (int i = 1; i < CAPACITY; i++) begin
                if (r_hit ? (PW'(i) <= r_pos) : (CW'(i) <= r_count))
                    r_list[i] <= r_list[i-1];
            end
        end else if (w_do_era) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (PW'(i) >= r_pos) r_list[i] <= r_list[i+1];
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_victim = r_victim;
    assign o_count  = r_count;

endmodule

// ===== rtl/lru_replacer_unit.sv =====
// Top level of the LRU replacer: stream ports, front end, queue and back end.
//
// Requests arrive on the s_axis channel, one beat each: insert/touch,
// victim (remove least recent) or erase. Every request gives exactly one
// result beat on m_axis with a status, the removed key of a successful
// victim, and the key count after the request.
// The back end handles each request in a compare state, for the parallel
// key compare across the recency list, then an execute state that shifts
// the list and registers the result. It compares a new request only after
// the last one has executed, and the execute state waits while a finished
// result is stalled on m_axis.
// A two-entry queue sits between the front end and the back end, so
// requests are taken while a result waits; when m_axis is stalled the back
// end holds its finished result, the queue fills and s_axis tready drops.
// Reset (synchronous, active low) empties the list and the queue and drops
// the output valid; list contents need no clearing since only entries
// below the count are ever read.
`timescale 1ns / 1ps
module lru_replacer_unit #(
    parameter  int unsigned CAPACITY  = 64,
    parameter  int unsigned KEY_WIDTH = 16,
    localparam int unsigned CW        = $clog2(CAPACITY + 1),
    localparam int unsigned IN_W      = ((lru_pkg::KIND_W + KEY_WIDTH + 7) / 8) * 8,
    localparam int unsigned OUT_W     = ((lru_pkg::STATUS_W + KEY_WIDTH + CW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // kind, key
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // status, victim_key, count
);
    import lru_pkg::*;

    localparam int unsigned OUT_USED = STATUS_W + KEY_WIDTH + CW;

    logic                 w_q_valid;
    logic                 w_q_pop;
    t_op                  w_q_op;
    logic [KEY_WIDTH-1:0] w_q_key;
    t_status              w_status;
    logic [KEY_WIDTH-1:0] w_victim;
    logic [CW-1:0]        w_count;

    lru_front #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_kind    (i_s_axis_tdata[KIND_W-1:0]),
        .i_key     (i_s_axis_tdata[KIND_W +: KEY_WIDTH]),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_op    (w_q_op),
        .o_q_key   (w_q_key)
    );

    lru_back #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .CW        (CW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_op    (w_q_op),
        .i_q_key   (w_q_key),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_status  (w_status),
        .o_victim  (w_victim),
        .o_count   (w_count)
    );

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[OUT_USED-1:0] = {w_count, w_victim, w_status};
    end

    `include "lru_replacer_unit_assert.svh"

    `LRU_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_m_axis_tvalid, (w_count <= CW'(CAPACITY)), "count above capacity")
    `LRU_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_m_axis_tvalid && (w_status == ST_FULL), (w_count == CW'(CAPACITY)), "full status while not full")
    `LRU_ASSERT_NOW(a_victim_ok, i_clk, i_rst_n, o_m_axis_tvalid && (w_victim != '0), (w_status == ST_OK) && (w_count < CW'(CAPACITY)), "victim key on failed request")
    `LRU_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, w_q_pop, o_m_axis_tvalid, "queue pop without result")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking stream testbench for lru_replacer_unit with a recency-list predictor.
`timescale 1ns / 1ps
module tb_top;
    import lru_pkg::*;

    localparam int unsigned CAPACITY  = 64;
    localparam int unsigned KEY_WIDTH = 16;
    localparam int unsigned CW        = $clog2(CAPACITY + 1);
    localparam int unsigned IN_W      = ((KIND_W + KEY_WIDTH + 7) / 8) * 8;
    localparam int unsigned OUT_W     = ((STATUS_W + KEY_WIDTH + CW + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int KEY_POOL_SIZE  = 80;

    typedef struct packed {
        t_status              status;
        logic [KEY_WIDTH-1:0] victim_key;
        logic [CW-1:0]        count;
    } t_lru_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;   // kind, key
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;   // status, victim_key, count

    lru_replacer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    logic [KEY_WIDTH-1:0] lru_order [CAPACITY];
    int                   lru_held;
    t_lru_result          due_results [$];
    logic [KEY_WIDTH-1:0] key_pool [KEY_POOL_SIZE];

    int error_count;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_off_req;
    int hold_off_left;
    int stuck_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Predictor: entry 0 is most recent, lru_held-1 least recent.
    task automatic lru_apply(input t_op op, input logic [KEY_WIDTH-1:0] key,
                             output t_lru_result res);
        int pos;
        pos = -1;
        res.status     = ST_OK;
        res.victim_key = '0;
        for (int i = 0; i < lru_held; i++)
            if (pos < 0 && lru_order[i] == key) pos = i;
        case (op)
            OP_INSERT: begin
                if (pos >= 0) begin
                    for (int i = pos; i > 0; i--) lru_order[i] = lru_order[i-1];
                    lru_order[0] = key;
                end else if (lru_held >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = lru_held; i > 0; i--) lru_order[i] = lru_order[i-1];
                    lru_order[0] = key;
                    lru_held++;
                end
            end
            OP_VICTIM: begin
                if (lru_held == 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    lru_held--;
                    res.victim_key = lru_order[lru_held];
                end
            end
            OP_ERASE: begin
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < lru_held; i++) lru_order[i] = lru_order[i+1];
                    lru_held--;
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            default: res.status = ST_NOTFOUND;
        endcase
        res.count = CW'(lru_held);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_op op, input logic [KEY_WIDTH-1:0] key);
        t_lru_result res;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_W'({key, op});
        do @(posedge i_clk); while (!o_s_axis_tready);
        lru_apply(op, key, res);
        due_results = {due_results, res};
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        if (error_count < 40)
            $display("tb_top: mismatch in %s at %0t: got %0d, want %0d",
                     field, $realtime, got, want);
        error_count++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_lru_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = due_results.pop_front();
                if (o_m_axis_tdata[1:0] != want.status)
                    report_mismatch("status", o_m_axis_tdata[1:0], want.status);
                if (o_m_axis_tdata[2 +: KEY_WIDTH] != want.victim_key)
                    report_mismatch("victim_key", o_m_axis_tdata[2 +: KEY_WIDTH],
                                    want.victim_key);
                if (o_m_axis_tdata[2 + KEY_WIDTH +: CW] != want.count)
                    report_mismatch("count", o_m_axis_tdata[2 + KEY_WIDTH +: CW],
                                    want.count);
            end
        end
    end

    // Result sink: random stalls plus requested hold-offs
    always @(negedge i_clk) begin
        if (hold_off_req > 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 85) return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        if (r < 95) return KEY_WIDTH'($urandom);
        return (r[0]) ? '1 : '0;
    endfunction

    task automatic wait_results_drained();
        while (due_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_request(OP_VICTIM, 16'h0000);
        send_request(OP_ERASE,  16'h0000);
        send_request(OP_BAD,    16'hFFFF);
        send_request(OP_INSERT, 16'h0000);
        send_request(OP_INSERT, 16'hFFFF);
        send_request(OP_INSERT, 16'h1234);
        send_request(OP_INSERT, 16'h0000);
        send_request(OP_VICTIM, 16'hFFFF);
        send_request(OP_ERASE,  16'h1234);
        send_request(OP_ERASE,  16'h1234);
        send_request(OP_INSERT, 16'hAAAA);
        send_request(OP_INSERT, 16'h5555);
        send_request(OP_BAD,    16'h0000);
        send_request(OP_ERASE,  16'hAAAA);
        send_request(OP_VICTIM, 16'h0000);
        send_request(OP_VICTIM, 16'h0000);
        send_request(OP_VICTIM, 16'h0000);
        send_request(OP_ERASE,  16'hFFFF);
    endtask

    task automatic test_full_table();
        int i;
        i = 0;
        while (lru_held < CAPACITY) begin
            send_request(OP_INSERT, KEY_WIDTH'(i * 1021) ^ 16'hC3A5);
            i++;
        end
        send_request(OP_INSERT, 16'hFFFF);
        send_request(OP_INSERT, lru_order[CAPACITY-1]);
        send_request(OP_INSERT, lru_order[17]);
        send_request(OP_BAD,    16'h0001);
        send_request(OP_VICTIM, 16'h0000);
        send_request(OP_INSERT, 16'h0000);
        send_request(OP_INSERT, 16'hFFFF);
        send_request(OP_ERASE,  lru_order[30]);
        send_request(OP_INSERT, 16'hFFFF);
    endtask

    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        int ins_w;
        int era_w;
        int r;
        t_op op;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            // alternate growing and shrinking stretches so the count sweeps its range
            if ((n / 60) % 2 == 0) begin
                ins_w = 60; era_w = 20;
            end else begin
                ins_w = 25; era_w = 35;
            end
            r = $urandom_range(99);
            if (r < ins_w)              op = OP_INSERT;
            else if (r < ins_w + era_w) op = OP_ERASE;
            else if (r < 96)            op = OP_VICTIM;
            else                        op = OP_BAD;
            if (op == OP_ERASE && lru_held > 0 && $urandom_range(1))
                send_request(op, lru_order[$urandom_range(lru_held - 1)]);
            else
                send_request(op, pick_key());
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_req   = 200;
        for (int n = 0; n < 16; n++) send_request(t_op'($urandom_range(2)), pick_key());
        i_s_axis_tvalid <= 1'b0;
        wait_results_drained();
        for (int n = 0; n < 8; n++) send_request(t_op'($urandom_range(2)), pick_key());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        error_count     = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_off_req    = 0;
        hold_off_left   = 0;
        stuck_cycles    = 0;
        lru_held        = 0;
        for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = KEY_WIDTH'($urandom);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random(200, 0, 0);
        test_random(200, 49, 0);
        test_backpressure();
        test_random(200, 0, 49);
        test_random(200, 24, 24);

        i_s_axis_tvalid <= 1'b0;
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
